/* src/aaf_hc_pkg.sv */
// shared types and constants of the aaf listener header check
`default_nettype none

package aaf_hc_pkg;

	// fixed avtp aaf header length in bytes
	localparam int HeaderBytes = 24;

	// width of the item capacity register and of the write offset
	localparam int ItemWidth = 24;

	// item capacity after reset
	localparam logic [ItemWidth-1:0] ItemBytesReset = 24'd1;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_FORMAT     = 3'd0,
		REG_RATE       = 3'd1,
		REG_CHANNELS   = 3'd2,
		REG_DEPTH      = 3'd3,
		REG_PAYLOAD    = 3'd4,
		REG_SPARSE     = 3'd5,
		REG_ITEM_BYTES = 3'd6
	} reg_idx_t;

	// configured stream format
	typedef struct packed {
		logic [7:0]           expect_format;
		logic [3:0]           expect_rate;
		logic [9:0]           expect_channels;
		logic [7:0]           expect_depth;
		logic [15:0]          expect_payload;
		logic                 sparse_enable;
		logic [ItemWidth-1:0] item_bytes;
	} cfg_t;

	// parsed header beat
	typedef struct packed {
		logic        ts_valid_bit;
		logic        ts_uncertain_bit;
		logic        sparse_bit;
		logic [15:0] stated_length;
		logic [31:0] stamp_word;
		logic [31:0] format_word;
		logic [31:0] packet_word;
		logic [15:0] frame_bytes;
		logic        buffer_ready;
	} in_beat_t;

	// result beat
	typedef struct packed {
		logic                 accepted;
		logic                 write_payload;
		logic [ItemWidth-1:0] write_offset;
		logic                 item_start;
		logic                 item_stamp_valid;
		logic                 item_stamp_uncertain;
		logic [31:0]          item_stamp;
		logic                 item_push;
		logic                 muted;
		logic                 buffer_full;
	} out_beat_t;

endpackage

`default_nettype wire

/* src/aaf_hc_in_if.sv */
// header input channel
`default_nettype none

interface aaf_hc_in_if;
	logic                 valid;
	logic                 ready;
	aaf_hc_pkg::in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/aaf_hc_out_if.sv */
// result output channel
`default_nettype none

interface aaf_hc_out_if;
	logic                  valid;
	logic                  ready;
	aaf_hc_pkg::out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/aaf_hc_cfg_if.sv */
// configuration write channel
`default_nettype none

interface aaf_hc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/aaf_hc_cfg.sv */
// configuration register file of the aaf header check
`default_nettype none

module aaf_hc_cfg (
	input  logic              clk,
	input  logic              arst_n,
	aaf_hc_cfg_if.sink        cfg,
	output aaf_hc_pkg::cfg_t  cfg_q
);

	aaf_hc_pkg::reg_idx_t idx;

	assign cfg.ready = 1'b1;
	assign idx = aaf_hc_pkg::reg_idx_t'(cfg.index);

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expect_format   <= '0;
			cfg_q.expect_rate     <= '0;
			cfg_q.expect_channels <= '0;
			cfg_q.expect_depth    <= '0;
			cfg_q.expect_payload  <= '0;
			cfg_q.sparse_enable   <= 1'b0;
			cfg_q.item_bytes      <= aaf_hc_pkg::ItemBytesReset;
		end else if (cfg.valid) begin
			unique case (idx)
				aaf_hc_pkg::REG_FORMAT:     cfg_q.expect_format   <= cfg.data[7:0];
				aaf_hc_pkg::REG_RATE:       cfg_q.expect_rate     <= cfg.data[3:0];
				aaf_hc_pkg::REG_CHANNELS:   cfg_q.expect_channels <= cfg.data[9:0];
				aaf_hc_pkg::REG_DEPTH:      cfg_q.expect_depth    <= cfg.data[7:0];
				aaf_hc_pkg::REG_PAYLOAD:    cfg_q.expect_payload  <= cfg.data[15:0];
				aaf_hc_pkg::REG_SPARSE:     cfg_q.sparse_enable   <= cfg.data[0];
				aaf_hc_pkg::REG_ITEM_BYTES: cfg_q.item_bytes      <= cfg.data[23:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/aaf_hc_check.sv */
// header validity check: frame length bounds and compare against the configured stream format
`default_nettype none

module aaf_hc_check (
	input  aaf_hc_pkg::in_beat_t hdr,
	input  aaf_hc_pkg::cfg_t     cfg_q,
	output logic                 ok
);

	logic [16:0] room;
	logic        too_short;
	logic        too_long;
	logic        fmt_match;

	// space left after the header, borrow marks a short frame
	assign room      = {1'b0, hdr.frame_bytes} - 17'(aaf_hc_pkg::HeaderBytes);
	assign too_short = room[16];
	assign too_long  = {1'b0, hdr.stated_length} > room;

	// format, rate, channels, depth, payload size and sparse mode
	assign fmt_match = (hdr.format_word[31:24] == cfg_q.expect_format)
		&& (hdr.format_word[23:20] == cfg_q.expect_rate)
		&& (hdr.format_word[17:8] == cfg_q.expect_channels)
		&& (hdr.format_word[7:0] == cfg_q.expect_depth)
		&& (hdr.packet_word[31:16] == cfg_q.expect_payload)
		&& (hdr.sparse_bit == cfg_q.sparse_enable);

	assign ok = !too_short && !too_long && fmt_match;

endmodule

`default_nettype wire

/* src/aaf_listener_header_check.sv */
// aaf listener header check top level: input register, buffer steering, result register
//
// channel  dir  handshake      payload
// hdr      in   valid/ready    parsed header fields, one packet a beat
// res      out  valid/ready    one result beat per header beat
// cfg      in   valid/ready    register index and write data, always ready
//
// a header beat is captured in the input register, judged and steered from there, and
// its result is captured in the result register; one beat per cycle is sustained while
// res.ready holds, since fill level and sync flag are updated together on each advance.
// arst_n clears both stage valids and the state (stream valid, not synced, empty item).
// a stalled result register holds a full input stage, which then drops hdr.ready.
`default_nettype none

module aaf_listener_header_check #(
	parameter int FILL_WIDTH = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	aaf_hc_in_if.sink    hdr,
	aaf_hc_out_if.source res,
	aaf_hc_cfg_if.sink   cfg
);

	localparam int SumW = (FILL_WIDTH + 1 > aaf_hc_pkg::ItemWidth + 1) ?
		FILL_WIDTH + 1 : aaf_hc_pkg::ItemWidth + 1;

	aaf_hc_pkg::cfg_t      cfg_q;
	aaf_hc_pkg::in_beat_t  beat_s1;
	aaf_hc_pkg::out_beat_t beat_s2;
	aaf_hc_pkg::out_beat_t result;
	logic                  valid_s1;
	logic                  valid_s2;

	logic                  stream_ok_q;
	logic                  stamp_synced_q;
	logic [FILL_WIDTH-1:0] fill_q;

	logic                  ok;
	logic                  advance;
	logic                  take;
	logic                  empty;
	logic                  stamp_start;
	logic                  write;
	logic [SumW-1:0]       fill_w;
	logic [SumW-1:0]       sum;
	logic                  push;

	aaf_hc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	aaf_hc_check u_check (
		.hdr   (beat_s1),
		.cfg_q (cfg_q),
		.ok    (ok)
	);

	// stage handshake
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign hdr.ready = !valid_s1 || advance;

	// buffer steering
	assign take        = ok && beat_s1.buffer_ready;
	assign empty       = (fill_q == '0);
	assign stamp_start = empty && beat_s1.ts_valid_bit;
	assign write       = !(empty && !beat_s1.ts_valid_bit && !stamp_synced_q);
	assign fill_w      = SumW'(fill_q);
	assign sum         = write ? fill_w + SumW'(cfg_q.expect_payload) : fill_w;
	assign push        = sum >= SumW'(cfg_q.item_bytes);

	// result beat
	always_comb begin
		result.accepted             = take;
		result.write_payload        = take && write;
		result.write_offset         = (take && write) ?
			fill_w[aaf_hc_pkg::ItemWidth-1:0] : '0;
		result.item_start           = take && empty && (beat_s1.ts_valid_bit || stamp_synced_q);
		result.item_stamp_valid     = take && stamp_start;
		result.item_stamp_uncertain = take && stamp_start && beat_s1.ts_uncertain_bit;
		result.item_stamp           = (take && stamp_start) ? beat_s1.stamp_word : '0;
		result.item_push            = take && push;
		result.muted                = !ok;
		result.buffer_full          = ok && !beat_s1.buffer_ready;
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr.ready && hdr.valid) begin
			beat_s1 <= hdr.data;
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_ok_q    <= 1'b1;
			stamp_synced_q <= 1'b0;
			fill_q         <= '0;
		end else if (advance) begin
			stream_ok_q <= ok;
			if (take) begin
				if (stamp_start) begin
					stamp_synced_q <= 1'b1;
				end
				fill_q <= push ? '0 : sum[FILL_WIDTH-1:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beat_s2 <= result;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = beat_s2;

	// the sync flag never drops once set
	a_sync_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(stamp_synced_q))
		else $error("stamp sync flag cleared");

	// a push or a payload write only on an accepted packet
	a_push_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (beat_s2.item_push || beat_s2.write_payload) |-> beat_s2.accepted)
		else $error("push or write without acceptance");

	// a muted result is neither accepted nor refused for space
	a_muted_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && beat_s2.muted |-> !beat_s2.accepted && !beat_s2.buffer_full)
		else $error("muted packet steered");

	// the waiting result's mute flag follows the stream flag
	a_muted_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> beat_s2.muted == !stream_ok_q)
		else $error("mute flag differs from stream state");

	// fill level returns to empty after a push
	a_push_empties: assert property (@(posedge clk) disable iff (!arst_n)
		advance && take && push |=> fill_q == '0)
		else $error("fill level kept after push");

endmodule

`default_nettype wire
